// ===== rtl/pba_pkg.sv =====
// shared types and constants for the pooled bump allocator
// no dependencies
`timescale 1ns / 1ps

package pba_pkg;

	localparam int NUM_POOLS_DEF = 16;
	localparam int CHUNK_W = 21;
	localparam logic [CHUNK_W-1:0] CHUNK_RESET = 21'd20480;

	// result codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_ROOM = 2'd1;
	localparam logic [1:0] ST_NO_POOL = 2'd2;
	localparam logic [1:0] ST_BAD_SZ  = 2'd3;

	// register index (byte address bit 2)
	localparam logic REG_WORKSPACE = 1'b0;
	localparam logic REG_CHUNK     = 1'b1;

	typedef struct packed {
		logic       cap;
		logic       scan_clr;
		logic       scan_step;
		logic       take_hit;
		logic       claim;
		logic       div_go;
		logic       div_chunk;
		logic       count_ld;
		logic       bump_fin;
		logic       pool_fin;
		logic       set_err;
		logic [1:0] err_code;
		logic       out_ld;
	} pba_cmd_t;

	typedef struct packed {
		logic op;
		logic align_zero;
		logic bad_size;
		logic scan_hit;
		logic scan_last;
		logic empty_any;
		logic left_zero;
		logic div_done;
		logic out_busy;
	} pba_sts_t;

endpackage

// ===== rtl/pba_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on nothing
`timescale 1ns / 1ps

module pba_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic [31:0] quo,
	output logic [31:0] rem,
	output logic        done
);
	logic [31:0] quo_q, rem_q, dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign quo  = quo_q;
	assign rem  = rem_q;
	assign done = done_q;
endmodule

// ===== rtl/pba_datapath.sv =====
// allocator datapath: request latch, pool tables, fill point, bump check, result register
// depends on pba_pkg and pba_div
`timescale 1ns / 1ps

module pba_datapath #(
	parameter int NUM_POOLS = pba_pkg::NUM_POOLS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pba_pkg::pba_cmd_t       cmd,
	output pba_pkg::pba_sts_t       sts,
	input  logic                    operation,
	input  logic [31:0]             request_size,
	input  logic [15:0]             alignment,
	input  logic [31:0]             ws,
	input  logic [pba_pkg::CHUNK_W-1:0] chunk,
	input  logic                    out_stall,
	output logic                    out_valid,
	output logic [1:0]              status,
	output logic [31:0]             position
);
	import pba_pkg::*;

	localparam int PW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;

	logic              op_q;
	logic [31:0]       size_q;
	logic [15:0]       align_q;
	logic [31:0]       used_q;
	logic [PW-1:0]     idx_q, hit_q, empty_q;
	logic              empty_vld_q;
	logic [31:0]       pool_size_q [NUM_POOLS];
	logic [CHUNK_W-1:0] pool_left_q [NUM_POOLS];
	logic [31:0]       pool_idx_q  [NUM_POOLS];
	logic [CHUNK_W-1:0] count_q, crem_q;
	logic [1:0]        res_status_q, out_status_q;
	logic [31:0]       res_pos_q, out_pos_q;
	logic              out_valid_q;

	logic [31:0] div_quo, div_rem, div_a, div_b;
	logic        div_done;
	logic        cur_empty;
	logic [PW-1:0] claim_idx;

	// bump check
	logic [31:0] d, r, pad, at, room, bsize, new_used, base_idx;
	logic [32:0] at1;
	logic        has_pad, pad_fail, bump_ok;

	assign div_a = cmd.div_chunk ? {{(32-CHUNK_W){1'b0}}, chunk} : used_q;
	assign div_b = op_q ? size_q : {16'b0, align_q};

	pba_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_go),
		.dividend(div_a),
		.divisor (div_b),
		.quo     (div_quo),
		.rem     (div_rem),
		.done    (div_done)
	);

	assign cur_empty = (pool_size_q[idx_q] == 32'd0);
	assign claim_idx = cur_empty ? idx_q : empty_q;

	always_comb begin
		d        = div_b;
		r        = (!op_q && align_q == 16'd0) ? 32'd0 : div_rem;
		has_pad  = (r != 32'd0);
		pad      = d - r;
		at1      = {1'b0, used_q} + {1'b0, pad};
		pad_fail = has_pad && (at1 > {1'b0, ws});
		at       = has_pad ? at1[31:0] : used_q;
		room     = (ws > at) ? (ws - at) : 32'd0;
		bsize    = op_q ? {{(32-CHUNK_W){1'b0}}, chunk - crem_q} : size_q;
		bump_ok  = !pad_fail && !(bsize > room);
		new_used = at + bsize;
		base_idx = div_quo + {31'b0, has_pad};
	end

	always_comb begin
		sts.op         = op_q;
		sts.align_zero = (align_q == 16'd0);
		sts.bad_size   = (size_q == 32'd0) || (size_q > {{(32-CHUNK_W){1'b0}}, chunk});
		sts.scan_hit   = (pool_size_q[idx_q] == size_q);
		sts.scan_last  = (idx_q == PW'(NUM_POOLS - 1));
		sts.empty_any  = empty_vld_q || cur_empty;
		sts.left_zero  = (pool_left_q[hit_q] == '0);
		sts.div_done   = div_done;
		sts.out_busy   = out_valid_q && out_stall;
	end

	// control-side registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			idx_q       <= '0;
			empty_vld_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_POOLS; i++) begin
				pool_size_q[i] <= '0;
				pool_left_q[i] <= '0;
			end
		end else begin
			if (cmd.scan_clr) begin
				idx_q       <= '0;
				empty_vld_q <= 1'b0;
			end else if (cmd.scan_step) begin
				idx_q <= idx_q + PW'(1);
				if (cur_empty)
					empty_vld_q <= 1'b1;
			end
			if (cmd.claim) begin
				pool_size_q[claim_idx] <= size_q;
				pool_left_q[claim_idx] <= '0;
			end
			if (cmd.bump_fin && bump_ok) begin
				used_q <= new_used;
				if (op_q)
					pool_left_q[hit_q] <= count_q - CHUNK_W'(1);
			end
			if (cmd.pool_fin)
				pool_left_q[hit_q] <= pool_left_q[hit_q] - CHUNK_W'(1);
			if (cmd.out_ld)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q    <= operation;
			size_q  <= request_size;
			align_q <= alignment;
		end
		if (cmd.scan_step && cur_empty)
			empty_q <= idx_q;
		if (cmd.take_hit)
			hit_q <= idx_q;
		if (cmd.claim)
			hit_q <= claim_idx;
		if (cmd.count_ld) begin
			count_q <= div_quo[CHUNK_W-1:0];
			crem_q  <= div_rem[CHUNK_W-1:0];
		end
		if (cmd.set_err) begin
			res_status_q <= cmd.err_code;
			res_pos_q    <= '0;
		end
		if (cmd.bump_fin) begin
			if (!bump_ok) begin
				res_status_q <= ST_NO_ROOM;
				res_pos_q    <= '0;
			end else if (op_q) begin
				res_status_q       <= ST_OK;
				res_pos_q          <= base_idx;
				pool_idx_q[hit_q]  <= base_idx + 32'd1;
			end else begin
				res_status_q <= ST_OK;
				res_pos_q    <= at;
			end
		end
		if (cmd.pool_fin) begin
			res_status_q      <= ST_OK;
			res_pos_q         <= pool_idx_q[hit_q];
			pool_idx_q[hit_q] <= pool_idx_q[hit_q] + 32'd1;
		end
		if (cmd.out_ld) begin
			out_status_q <= res_status_q;
			out_pos_q    <= res_pos_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign position  = out_pos_q;
endmodule

// ===== rtl/pba_ctrl.sv =====
// allocator sequencer: walks one request through decode, pool scan, division and commit
// depends on pba_pkg
`timescale 1ns / 1ps

module pba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  pba_pkg::pba_sts_t sts,
	output pba_pkg::pba_cmd_t cmd
);
	import pba_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_DEC  = 10'b00_0000_0010,
		S_SCAN = 10'b00_0000_0100,
		S_HIT  = 10'b00_0000_1000,
		S_CDIV = 10'b00_0001_0000,
		S_UDIV = 10'b00_0010_0000,
		S_RDIV = 10'b00_0100_0000,
		S_RFIN = 10'b00_1000_0000,
		S_PFIN = 10'b01_0000_0000,
		S_DONE = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (!sts.op) begin
					if (sts.align_zero) begin
						state_d = S_RFIN;
					end else begin
						cmd.div_go = 1'b1;
						state_d    = S_RDIV;
					end
				end else if (sts.bad_size) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = ST_BAD_SZ;
					state_d      = S_DONE;
				end else begin
					cmd.scan_clr = 1'b1;
					state_d      = S_SCAN;
				end
			end
			S_SCAN: begin
				priority if (sts.scan_hit) begin
					cmd.take_hit = 1'b1;
					state_d      = S_HIT;
				end else if (sts.scan_last) begin
					if (sts.empty_any) begin
						cmd.claim = 1'b1;
						state_d   = S_HIT;
					end else begin
						cmd.set_err  = 1'b1;
						cmd.err_code = ST_NO_POOL;
						state_d      = S_DONE;
					end
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_HIT: begin
				if (sts.left_zero) begin
					cmd.div_go    = 1'b1;
					cmd.div_chunk = 1'b1;
					state_d       = S_CDIV;
				end else begin
					state_d = S_PFIN;
				end
			end
			S_CDIV: begin
				if (sts.div_done) begin
					cmd.count_ld = 1'b1;
					cmd.div_go   = 1'b1;
					state_d      = S_UDIV;
				end
			end
			S_UDIV, S_RDIV: begin
				if (sts.div_done)
					state_d = S_RFIN;
			end
			S_RFIN: begin
				cmd.bump_fin = 1'b1;
				state_d      = S_DONE;
			end
			S_PFIN: begin
				cmd.pool_fin = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end
endmodule

// ===== rtl/pooled_bump_allocator.sv =====
// pooled bump allocator top level: apb register file, sequencer and datapath
// depends on pba_pkg, pba_ctrl, pba_datapath
`timescale 1ns / 1ps
// usage:
//  - request channel (in_valid/in_stall): operation, request_size, alignment; one item
//    is taken at a time, in_stall stays high from acceptance until the result is loaded
//  - result channel (out_valid/out_stall): status and position, held in an output
//    register; a stalled result holds and the sequencer waits before loading the next
//  - apb port: workspace_bytes at 0x0, chunk_bytes at 0x4; write only while idle
//  - path from acceptance to out_valid: a raw request without alignment goes straight
//    to the bump check; with alignment it first makes one pass of the 32-step divider;
//    a pooled hit in a filled pool scans the pools up to the match before committing; a
//    pool refill runs the divider twice (chunk / size, then fill point / size); the
//    worst item is a refill after a full scan of 16 pools
//  - the next item is taken the cycle after the result is loaded, so a new item is
//    accepted only once the previous result has been loaded
//  - reset clears the fill point and all pools, restores chunk_bytes to 20480 and
//    workspace_bytes to 0; no clearing pass is needed
//  - pool indices are tracked directly, so item position needs no extra division
module pooled_bump_allocator #(
	parameter int NUM_POOLS = pba_pkg::NUM_POOLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [31:0] request_size,
	input  logic [15:0] alignment,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] position,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pba_pkg::*;

	logic [31:0]        ws_q;
	logic [CHUNK_W-1:0] chunk_q;
	pba_cmd_t           cmd;
	pba_sts_t           sts;

	// register file, bit 2 of the byte address picks the register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q    <= '0;
			chunk_q <= CHUNK_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_WORKSPACE: ws_q    <= pwdata;
				REG_CHUNK:     chunk_q <= pwdata[CHUNK_W-1:0];
				default:       ;
			endcase
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CHUNK) ? {{(32-CHUNK_W){1'b0}}, chunk_q} : ws_q;

	// sequencer
	pba_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	// pool tables, fill point, divider and result register
	pba_datapath #(
		.NUM_POOLS(NUM_POOLS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.operation   (operation),
		.request_size(request_size),
		.alignment   (alignment),
		.ws          (ws_q),
		.chunk       (chunk_q),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.status      (status),
		.position    (position)
	);

	// a failed item always reports position zero
	a_fail_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (position == 32'd0))
		else $error("failed item carries nonzero position");

	// an accepted item never produces a result on the next cycle
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !(cmd.out_ld))
		else $error("result loaded right after acceptance");

	// a new item is taken only when the sequencer is not loading a result
	a_accept_vs_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.cap && cmd.out_ld))
		else $error("capture and result load collide");
endmodule

// ===== tb/sv/pooled_bump_allocator_test.sv =====
// self-checking testbench for pooled_bump_allocator: directed and random requests,
// apb register setup between phases, scoreboard with its own allocator prediction
// depends on pba_pkg and the pooled_bump_allocator rtl
`timescale 1ns / 1ps

// prediction of allocator results and queue of results still to come
class pba_scoreboard;
	localparam int POOLS = pba_pkg::NUM_POOLS_DEF;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] position;
	} alloc_result_t;

	bit [31:0] workspace_bytes;
	bit [31:0] chunk_bytes;
	bit [31:0] used_bytes;
	bit [31:0] item_size [POOLS];
	bit [31:0] items_left [POOLS];
	bit [31:0] next_offset [POOLS];
	alloc_result_t pending_results [$];
	int mismatches;
	int checked;
	int status_seen [4];

	function void clear_state();
		workspace_bytes = 0;
		chunk_bytes = {{(32-pba_pkg::CHUNK_W){1'b0}}, pba_pkg::CHUNK_RESET};
		used_bytes = 0;
		foreach (item_size[i]) begin
			item_size[i] = 0;
			items_left[i] = 0;
			next_offset[i] = 0;
		end
		pending_results.delete();
		mismatches = 0;
		checked = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
	endfunction

	// advance the fill point, padded to a nonzero alignment
	function bit reserve(bit [31:0] size, bit [31:0] align, output bit [31:0] where);
		bit [31:0] at;
		bit [31:0] pad;
		bit [31:0] room;
		at = used_bytes;
		where = 0;
		if (align != 0 && (at % align) != 0) begin
			pad = align - (at % align);
			room = (workspace_bytes > at) ? workspace_bytes - at : 32'd0;
			if (pad > room) return 1'b0;
			at = at + pad;
		end
		room = (workspace_bytes > at) ? workspace_bytes - at : 32'd0;
		if (size > room) return 1'b0;
		used_bytes = at + size;
		where = at;
		return 1'b1;
	endfunction

	function void note_request(bit op, bit [31:0] size, bit [15:0] align);
		alloc_result_t r;
		int hit;
		int empty;
		bit [31:0] at;
		bit [31:0] count;
		bit [31:0] off;
		r.status = pba_pkg::ST_OK;
		r.position = 0;
		hit = -1;
		empty = -1;
		if (op == 1'b0) begin
			if (reserve(size, {16'd0, align}, at)) r.position = at;
			else r.status = pba_pkg::ST_NO_ROOM;
		end else if (size == 0 || size > chunk_bytes) begin
			r.status = pba_pkg::ST_BAD_SZ;
		end else begin
			for (int i = 0; i < POOLS && hit < 0; i++) begin
				if (item_size[i] == 0) empty = i;
				if (item_size[i] == size) hit = i;
			end
			if (hit < 0 && empty >= 0) begin
				hit = empty;
				item_size[hit] = size;
				items_left[hit] = 0;
			end
			if (hit < 0) begin
				r.status = pba_pkg::ST_NO_POOL;
			end else begin
				if (items_left[hit] == 0) begin
					count = chunk_bytes / size;
					if (reserve(count * size, size, at)) begin
						items_left[hit] = count;
						next_offset[hit] = at;
					end else begin
						r.status = pba_pkg::ST_NO_ROOM;
					end
				end
				if (r.status == pba_pkg::ST_OK) begin
					off = next_offset[hit];
					items_left[hit] = items_left[hit] - 1;
					next_offset[hit] = off + size;
					r.position = off / size;
				end
			end
		end
		pending_results.push_back(r);
	endfunction

	function void check_result(logic [1:0] status, logic [31:0] position);
		alloc_result_t e;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected result status=%0d position=%0h",
					$realtime, status, position);
			return;
		end
		e = pending_results.pop_front();
		checked++;
		status_seen[e.status]++;
		if (status !== e.status || position !== e.position) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result %0d expected status=%0d position=%0h, %s",
					$realtime, checked, e.status, e.position,
					$sformatf("got status=%0d position=%0h", status, position));
		end
	endfunction
endclass

module pooled_bump_allocator_test;
	import pba_pkg::*;

	localparam logic OP_RAW  = 1'b0;
	localparam logic OP_POOL = 1'b1;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 150;   // longest request is a refill

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        operation;
	logic [31:0] request_size;
	logic [15:0] alignment;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [31:0] position;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	pba_scoreboard alloc_sb;
	int  cycle_count;
	int  items_sent;
	bit  quiet_sender;    // no gaps on the request side
	bit  quiet_receiver;  // no stalls on the result side

	// pooled item sizes reused throughout, so pools stay in play after they are claimed
	bit [31:0] pool_sizes [12] = '{1, 2, 3, 4, 8, 12, 24, 64, 100, 1000, 4096, 20480};

	pooled_bump_allocator DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .request_size(request_size), .alignment(alignment),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .position(position),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, alloc_sb.pending_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side: random stalls, and every accepted result goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			alloc_sb.check_result(status, position);
		out_stall <= quiet_receiver ? 1'b0 : ($urandom_range(0, 99) < 19);
	end

	task automatic wait_cycles(int n);
		repeat (n) @(posedge clk);
	endtask

	// apb write: setup cycle then access cycle, pready is always high
	task automatic write_reg(logic reg_index, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_index, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_index == REG_WORKSPACE) alloc_sb.workspace_bytes = value;
		else alloc_sb.chunk_bytes = {{(32-CHUNK_W){1'b0}}, value[CHUNK_W-1:0]};
	endtask

	// let every result drain, plus the latency of anything still running
	task automatic wait_idle();
		while (alloc_sb.pending_results.size() != 0) @(posedge clk);
		wait_cycles(DRAIN_CYCLES);
	endtask

	// present one item and hold it until accepted; a gap may follow
	task automatic send_item(logic op, logic [31:0] size, logic [15:0] align);
		in_valid     <= 1'b1;
		operation    <= op;
		request_size <= size;
		alignment    <= align;
		do @(posedge clk); while (in_stall);
		alloc_sb.note_request(op, size, align);
		items_sent++;
		if (!quiet_sender && $urandom_range(0, 99) < 19) begin
			in_valid <= 1'b0;
			wait_cycles($urandom_range(1, 6));
		end
	endtask

	task automatic send_random();
		int pick;
		logic [31:0] size;
		logic [15:0] align;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 45) begin
			// raw request: mostly small, a few of any size
			if (pick < 70) size = $urandom_range(0, 300);
			else if (pick < 95) size = $urandom_range(0, 70000);
			else size = $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 30) align = '0;
			else if (pick < 70) align = 16'd1 << $urandom_range(0, 12);
			else if (pick < 90) align = 16'($urandom_range(1, 100));
			else align = 16'($urandom);
			send_item(OP_RAW, size, align);
		end else begin
			// pooled request: known sizes, with some zero and some oversized
			if (pick < 85) size = pool_sizes[$urandom_range(0, 11)];
			else if (pick < 90) size = '0;
			else size = $urandom;
			send_item(OP_POOL, size, 16'($urandom));
		end
	endtask

	// random phase with a quiet window in the middle and one full drain
	task automatic random_phase(int count);
		for (int i = 0; i < count; i++) begin
			quiet_sender = (i >= count / 3 && i < count / 3 + 60);
			quiet_receiver = quiet_sender;
			if (i == count / 2) begin
				in_valid <= 1'b0;
				while (alloc_sb.pending_results.size() != 0) @(posedge clk);
			end
			send_random();
		end
		quiet_sender = 1'b0;
		quiet_receiver = 1'b0;
		in_valid <= 1'b0;
	endtask

	initial begin
		alloc_sb = new();
		alloc_sb.clear_state();
		cycle_count = 0;
		items_sent = 0;
		quiet_sender = 1'b0;
		quiet_receiver = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_RAW;
		request_size = '0;
		alignment = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		wait_cycles(6);
		arst_n <= 1'b1;
		wait_cycles(2);

		// empty workspace after reset: everything that needs room fails
		send_item(OP_RAW, 32'd1, 16'd0);
		send_item(OP_RAW, 32'd0, 16'd0);
		send_item(OP_POOL, 32'd16, 16'd0);
		send_item(OP_POOL, 32'd0, 16'd0);
		in_valid <= 1'b0;
		wait_idle();

		write_reg(REG_WORKSPACE, 32'd100000);
		// raw extremes and padding
		send_item(OP_RAW, 32'd3, 16'd0);
		send_item(OP_RAW, 32'd8, 16'hFFFF);
		send_item(OP_RAW, 32'd5, 16'd1);
		send_item(OP_RAW, 32'hFFFF_FFFF, 16'd4);
		send_item(OP_RAW, 32'd0, 16'd7);
		// pooled: bad sizes, a refill, a hit in a filled pool
		send_item(OP_POOL, 32'd20481, 16'd0);
		send_item(OP_POOL, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(OP_POOL, 32'd20480, 16'd0);
		send_item(OP_POOL, 32'd20480, 16'd0);
		send_item(OP_POOL, 32'd7, 16'd0);
		send_item(OP_POOL, 32'd7, 16'd0);
		// claim every pool, then two more sizes have nowhere to go
		for (int i = 0; i < 15; i++) send_item(OP_POOL, 32'd200 + i, 16'd0);
		in_valid <= 1'b0;
		wait_idle();

		// fill point beyond the workspace after lowering it
		write_reg(REG_WORKSPACE, alloc_sb.used_bytes - 32'd10);
		send_item(OP_RAW, 32'd0, 16'd0);
		send_item(OP_RAW, 32'd1, 16'd0);
		send_item(OP_RAW, 32'd0, 16'd3);
		send_item(OP_POOL, 32'd300, 16'd0);
		in_valid <= 1'b0;
		wait_idle();

		// random phases at several register settings; each leaves fresh room
		write_reg(REG_CHUNK, 32'd1048576);
		write_reg(REG_WORKSPACE, alloc_sb.used_bytes + 32'd40_000_000);
		random_phase(500);
		wait_idle();
		write_reg(REG_CHUNK, 32'd4096);
		write_reg(REG_WORKSPACE, alloc_sb.used_bytes + 32'd2_000_000);
		random_phase(500);
		wait_idle();
		write_reg(REG_CHUNK, 32'd20480);
		write_reg(REG_WORKSPACE, alloc_sb.used_bytes + 32'd300_000);
		random_phase(500);
		wait_idle();
		write_reg(REG_CHUNK, 32'd1);
		write_reg(REG_WORKSPACE, 32'hFFFF_FFFF);
		random_phase(300);
		wait_idle();

		$display("%0d requests sent, %0d results checked: ok %0d, no room %0d, %s",
			items_sent, alloc_sb.checked, alloc_sb.status_seen[ST_OK],
			alloc_sb.status_seen[ST_NO_ROOM],
			$sformatf("no pool %0d, bad size %0d", alloc_sb.status_seen[ST_NO_POOL],
				alloc_sb.status_seen[ST_BAD_SZ]));
		$display("workspace and chunk settings swept at both extremes, %0d mismatches",
			alloc_sb.mismatches);
		if (alloc_sb.mismatches == 0 && alloc_sb.pending_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/pba_pkg.sv
rtl/pba_div.sv
rtl/pba_datapath.sv
rtl/pba_ctrl.sv
rtl/pooled_bump_allocator.sv
tb/sv/pooled_bump_allocator_test.sv
